[rtl/core/irb_pkg.sv]
// Shared types and constants for the bilinear rotation block.
`timescale 1ns / 1ps
`default_nettype none
package irb_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int POS_W   = 10;
  localparam int PIX_W   = 8;
  localparam int FRAC_W  = 8;
  localparam int MAP_W   = 16;
  localparam int COEF_W  = 10;
  localparam int OFS_W   = 21;
  localparam int DIM_W   = 13;
  localparam int PROD_W  = 21;
  localparam int SUM_W   = 23;
  localparam int CIDX_W  = 4;
  localparam int CDATA_W = 21;
  localparam int QDEPTH  = 4;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_COMPUTE = 1'b1
  } item_kind_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_SRC_WIDTH  = 4'd0,
    REG_SRC_HEIGHT = 4'd1,
    REG_COEF_AX    = 4'd2,
    REG_COEF_BX    = 4'd3,
    REG_COEF_CX    = 4'd4,
    REG_COEF_AY    = 4'd5,
    REG_COEF_BY    = 4'd6,
    REG_COEF_CY    = 4'd7
  } cfg_reg_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    item_kind_t        kind;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [PIX_W-1:0]  pix;
    logic              in_src;
    logic [FRAC_W-1:0] fu;
    logic [FRAC_W-1:0] fv;
    logic [MAP_W-1:0]  map_x;
    logic [MAP_W-1:0]  map_y;
  } q_entry_t;

endpackage
`default_nettype wire

[rtl/core/image_rotate_bilinear_fixed_unit.sv]
// Top level of the fixed-point bilinear image rotation block.
// The block takes one item per cycle while its queue has room, which a stalled
// output can use up: a load writes one source pixel, a compute yields one
// result (coordinate multipliers registered at acceptance, then the queue, a
// memory read register and two blend multiplier stages). One item per cycle
// is possible because the source is kept in four banks split by row and
// column parity, so the four neighbors of any pixel sit in different banks.
// Loads produce no result.
// The source memory is not cleared; only pixels loaded earlier may be read.
// Configuration writes are taken every cycle and must be made while idle.
`timescale 1ns / 1ps
`default_nettype none
module image_rotate_bilinear_fixed_unit import irb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [POS_W-1:0]   pos_x,
  input  logic [POS_W-1:0]   pos_y,
  input  logic [PIX_W-1:0]   pixel_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   pixel_out,
  output logic               inside_res,
  output logic [MAP_W-1:0]   map_x,
  output logic [MAP_W-1:0]   map_y
);

  logic     q_push, q_ready, q_pop, q_nonempty;
  q_entry_t q_wdata, q_rdata;

  irb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .cmd, .pos_x, .pos_y, .pixel_in,
    .q_push, .q_ready, .q_data(q_wdata)
  );

  irb_queue u_queue (
    .clk, .rst, .push(q_push), .ready(q_ready), .wdata(q_wdata),
    .pop(q_pop), .nonempty(q_nonempty), .rdata(q_rdata)
  );

  irb_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk, .rst, .q_nonempty, .q_pop, .q_data(q_rdata),
    .out_valid, .out_ready, .pixel_out, .inside_res, .map_x, .map_y
  );

endmodule
`default_nettype wire

[rtl/core/irb_front.sv]
// Front end: configuration registers, coordinate mapping and classification.
`timescale 1ns / 1ps
`default_nettype none
module irb_front import irb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [POS_W-1:0]   pos_x,
  input  logic [POS_W-1:0]   pos_y,
  input  logic [PIX_W-1:0]   pixel_in,
  output logic               q_push,
  input  logic               q_ready,
  output q_entry_t           q_data
);

  logic [POS_W-1:0]        src_width, src_height;
  logic signed [COEF_W-1:0] coef_ax, coef_bx, coef_ay, coef_by;
  logic signed [OFS_W-1:0]  coef_cx, coef_cy;

  logic                     f1_valid;
  item_kind_t               f1_kind;
  logic [POS_W-1:0]         f1_x, f1_y;
  logic [PIX_W-1:0]         f1_pix;
  logic signed [PROD_W-1:0] f1_pax, f1_pbx, f1_pay, f1_pby;

  logic signed [SUM_W-1:0]  u_fix, v_fix, u_rnd, v_rnd;
  logic signed [SUM_W-FRAC_W-1:0] sx, sy;
  logic signed [DIM_W+2:0]  sx_ext, sy_ext, w_lim, h_lim;
  logic [DIM_W-1:0]         w_eff, h_eff;
  logic                     in_mem, in_src;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= POS_W'(512);
      src_height <= POS_W'(512);
      coef_ax    <= COEF_W'(256);
      coef_bx    <= '0;
      coef_cx    <= '0;
      coef_ay    <= '0;
      coef_by    <= COEF_W'(256);
      coef_cy    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width  <= cfg_data[POS_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[POS_W-1:0];
        REG_COEF_AX:    coef_ax    <= cfg_data[COEF_W-1:0];
        REG_COEF_BX:    coef_bx    <= cfg_data[COEF_W-1:0];
        REG_COEF_CX:    coef_cx    <= cfg_data[OFS_W-1:0];
        REG_COEF_AY:    coef_ay    <= cfg_data[COEF_W-1:0];
        REG_COEF_BY:    coef_by    <= cfg_data[COEF_W-1:0];
        REG_COEF_CY:    coef_cy    <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !f1_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f1_valid <= 1'b1;
    end else if (q_ready) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f1_kind <= item_kind_t'(cmd);
      f1_x    <= pos_x;
      f1_y    <= pos_y;
      f1_pix  <= pixel_in;
      f1_pax  <= coef_ax * $signed({1'b0, pos_x});
      f1_pbx  <= coef_bx * $signed({1'b0, pos_y});
      f1_pay  <= coef_ay * $signed({1'b0, pos_x});
      f1_pby  <= coef_by * $signed({1'b0, pos_y});
    end
  end

  always_comb begin
    u_fix = SUM_W'(f1_pax) + SUM_W'(f1_pbx) + SUM_W'(coef_cx);
    v_fix = SUM_W'(f1_pay) + SUM_W'(f1_pby) + SUM_W'(coef_cy);
    u_rnd = u_fix + SUM_W'(128);
    v_rnd = v_fix + SUM_W'(128);
    sx    = u_fix[SUM_W-1:FRAC_W];
    sy    = v_fix[SUM_W-1:FRAC_W];

    w_eff = ({3'b0, src_width} > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                     : {3'b0, src_width};
    h_eff = ({3'b0, src_height} > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                       : {3'b0, src_height};
    w_lim  = $signed({3'b0, w_eff}) - 16'sd1;
    h_lim  = $signed({3'b0, h_eff}) - 16'sd1;
    sx_ext = (DIM_W+3)'(sx);
    sy_ext = (DIM_W+3)'(sy);
    in_src = !sx[$high(sx)] && !sy[$high(sy)] && (sx_ext < w_lim) && (sy_ext < h_lim);

    in_mem = ({3'b0, f1_x} < DIM_W'(MAX_WIDTH)) && ({3'b0, f1_y} < DIM_W'(MAX_HEIGHT));

    q_data.kind   = f1_kind;
    q_data.pix    = f1_pix;
    q_data.in_src = in_src;
    q_data.fu     = u_fix[FRAC_W-1:0];
    q_data.fv     = v_fix[FRAC_W-1:0];
    // Negative coordinates wrap, so the rounded value is sign extended.
    q_data.map_x  = MAP_W'($signed(u_rnd[SUM_W-1:FRAC_W]));
    q_data.map_y  = MAP_W'($signed(v_rnd[SUM_W-1:FRAC_W]));
    if (f1_kind == KIND_LOAD) begin
      q_data.x = f1_x;
      q_data.y = f1_y;
    end else begin
      // Inside coordinates are below the source width and height, so ten bits hold them.
      q_data.x = sx[POS_W-1:0];
      q_data.y = sy[POS_W-1:0];
    end
  end

  // Loads that fall outside the memory are dropped here.
  assign q_push = f1_valid && q_ready && ((f1_kind == KIND_COMPUTE) || in_mem);

endmodule
`default_nettype wire

[rtl/core/irb_queue.sv]
// Small queue between the front end and the memory back end.
`timescale 1ns / 1ps
`default_nettype none
module irb_queue import irb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     ready,
  input  q_entry_t wdata,
  input  logic     pop,
  output logic     nonempty,
  output q_entry_t rdata
);

  localparam int PW = $clog2(QDEPTH);

  q_entry_t        slots [QDEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [PW:0]     count;

  assign ready    = (count != (PW+1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign rdata    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

endmodule
`default_nettype wire

[rtl/core/irb_back.sv]
// Back end: four-bank source memory, bilinear blend and output register.
`timescale 1ns / 1ps
`default_nettype none
module irb_back import irb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_nonempty,
  output logic              q_pop,
  input  q_entry_t          q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  pixel_out,
  output logic              inside_res,
  output logic [MAP_W-1:0]  map_x,
  output logic [MAP_W-1:0]  map_y
);

  localparam int HALF_W = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
  localparam int BDEPTH = HALF_W * HALF_H;
  localparam int AW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam logic [AW-1:0] HW = AW'(HALF_W);

  logic                adv;
  logic [AW-1:0]       addr  [4];
  logic [PIX_W-1:0]    rd    [4];
  logic [1:0]          wbank;
  logic                wr_en;

  logic                s1_valid, s1_inside, s1_xp, s1_yp;
  logic [FRAC_W-1:0]   s1_fu, s1_fv;
  logic [MAP_W-1:0]    s1_mx, s1_my;

  logic                s2_valid, s2_inside;
  logic [FRAC_W-1:0]   s2_fv;
  logic [15:0]         s2_top, s2_bot;
  logic [MAP_W-1:0]    s2_mx, s2_my;

  logic [PIX_W-1:0]    pa, pb, pc, pd;
  logic [8:0]          wu0, wu1, wv0, wv1;
  logic [15:0]         top, bot;
  logic [24:0]         acc;

  // The whole back end moves together; the queue absorbs a stalled output.
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_nonempty;
  assign wr_en = q_pop && (q_data.kind == KIND_LOAD);
  assign wbank = {q_data.y[0], q_data.x[0]};

  // Bank {yp,xp} holds pixels whose row parity is yp and column parity is xp.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [POS_W-1:0] col, row;
      if (q_data.kind == KIND_LOAD) begin
        col = q_data.x;
        row = q_data.y;
      end else begin
        col = q_data.x + POS_W'(q_data.x[0] != b[0]);
        row = q_data.y + POS_W'(q_data.y[0] != b[1]);
      end
      addr[b] = AW'(row[POS_W-1:1]) * HW + AW'(col[POS_W-1:1]);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [PIX_W-1:0] mem [BDEPTH];
    always_ff @(posedge clk) begin
      if (wr_en && (wbank == 2'(g))) mem[addr[g]] <= q_data.pix;
      if (adv) rd[g] <= mem[addr[g]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_pop && (q_data.kind == KIND_COMPUTE);
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_comb begin
    pa  = rd[{s1_yp, s1_xp}];
    pb  = rd[{s1_yp, !s1_xp}];
    pc  = rd[{!s1_yp, s1_xp}];
    pd  = rd[{!s1_yp, !s1_xp}];
    wu1 = {1'b0, s1_fu};
    wu0 = 9'd256 - wu1;
    top = {8'b0, pa} * {7'b0, wu0} + {8'b0, pb} * {7'b0, wu1};
    bot = {8'b0, pc} * {7'b0, wu0} + {8'b0, pd} * {7'b0, wu1};
    wv1 = {1'b0, s2_fv};
    wv0 = 9'd256 - wv1;
    acc = {9'b0, s2_top} * {16'b0, wv0} + {9'b0, s2_bot} * {16'b0, wv1} + 25'd32768;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_inside  <= q_data.in_src;
      s1_xp      <= q_data.x[0];
      s1_yp      <= q_data.y[0];
      s1_fu      <= q_data.fu;
      s1_fv      <= q_data.fv;
      s1_mx      <= q_data.map_x;
      s1_my      <= q_data.map_y;
      s2_inside  <= s1_inside;
      s2_fv      <= s1_fv;
      s2_top     <= top;
      s2_bot     <= bot;
      s2_mx      <= s1_mx;
      s2_my      <= s1_my;
      inside_res <= s2_inside;
      pixel_out  <= s2_inside ? acc[23:16] : '0;
      map_x      <= s2_mx;
      map_y      <= s2_my;
    end
  end

endmodule
`default_nettype wire

[rtl/core/irb_checker.sv]
// Port-level checks for the rotation block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module irb_checker import irb_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cfg_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] pixel_out,
  input logic             inside_res
);

  // A stalled result transaction keeps its pixel and inside flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(inside_res))
    else $error("output transaction changed while stalled");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_res |-> pixel_out == '0)
    else $error("outside pixel is not zero");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind image_rotate_bilinear_fixed_unit irb_checker u_irb_checker (
  .clk, .rst, .cfg_ready, .out_valid, .out_ready, .pixel_out, .inside_res
);
`default_nettype wire

[tb/image_rotate_bilinear_fixed_unit_test.sv]
// Self-checking testbench for the fixed-point bilinear image rotation block.
`timescale 1ns / 1ps
module image_rotate_bilinear_fixed_unit_test;
  import irb_pkg::*;

  localparam int MEM_W = MAX_WIDTH_DEF;
  localparam int MEM_H = MAX_HEIGHT_DEF;
  localparam int NUM_REGS = 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             in_src;
    logic [MAP_W-1:0] mx;
    logic [MAP_W-1:0] my;
  } rot_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CDATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [POS_W-1:0] pos_x = '0;
  logic [POS_W-1:0] pos_y = '0;
  logic [PIX_W-1:0] pixel_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PIX_W-1:0] pixel_out;
  logic inside_res;
  logic [MAP_W-1:0] map_x;
  logic [MAP_W-1:0] map_y;

  image_rotate_bilinear_fixed_unit uut (.*);

  always #5 clk = ~clk;

  // Shadow of the block's registers and source memory.
  int src_w, src_h;
  longint k_ax, k_bx, k_cx, k_ay, k_by, k_cy;
  logic [PIX_W-1:0] src_pix [MEM_W*MEM_H];
  bit loaded [MEM_W*MEM_H];

  rot_result_t pending_pixels[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int n_loads = 0, n_computes = 0, n_results = 0, n_inside = 0, n_cfg = 0;
  int quiet_cycles = 0;

  function automatic void map_source(input logic [POS_W-1:0] x, y,
                                     output longint u, v);
    u = k_ax * longint'(x) + k_bx * longint'(y) + k_cx;
    v = k_ay * longint'(x) + k_by * longint'(y) + k_cy;
  endfunction

  // Returns the base index of the 2x2 neighborhood, or -1 when outside.
  function automatic int neighborhood(input logic [POS_W-1:0] x, y);
    longint u, v, sx, sy;
    int w, h;
    map_source(x, y, u, v);
    sx = u >>> FRAC_W;
    sy = v >>> FRAC_W;
    w = (src_w < MEM_W) ? src_w : MEM_W;
    h = (src_h < MEM_H) ? src_h : MEM_H;
    if (sx >= 0 && sx < w - 1 && sy >= 0 && sy < h - 1) return int'(sy) * MEM_W + int'(sx);
    return -1;
  endfunction

  function automatic rot_result_t rotate_pixel(input logic [POS_W-1:0] x, y);
    rot_result_t r;
    longint u, v;
    longint unsigned fu, fv, acc;
    int base;
    map_source(x, y, u, v);
    base = neighborhood(x, y);
    r.pix = '0;
    r.in_src = 1'b0;
    if (base >= 0) begin
      fu = longint'(u[FRAC_W-1:0]);
      fv = longint'(v[FRAC_W-1:0]);
      acc = fu * fv * src_pix[base + MEM_W + 1]
          + (256 - fu) * fv * src_pix[base + MEM_W]
          + fu * (256 - fv) * src_pix[base + 1]
          + (256 - fu) * (256 - fv) * src_pix[base]
          + (1 << 15);
      r.pix = acc[23:16];
      r.in_src = 1'b1;
    end
    r.mx = 16'((u + 128) >>> FRAC_W);
    r.my = 16'((v + 128) >>> FRAC_W);
    return r;
  endfunction

  function automatic void shadow_config(input logic [CIDX_W-1:0] idx,
                                        input logic [CDATA_W-1:0] d);
    case (idx)
      REG_SRC_WIDTH: src_w = int'(d[9:0]);
      REG_SRC_HEIGHT: src_h = int'(d[9:0]);
      REG_COEF_AX: k_ax = longint'($signed(d[COEF_W-1:0]));
      REG_COEF_BX: k_bx = longint'($signed(d[COEF_W-1:0]));
      REG_COEF_CX: k_cx = longint'($signed(d[OFS_W-1:0]));
      REG_COEF_AY: k_ay = longint'($signed(d[COEF_W-1:0]));
      REG_COEF_BY: k_by = longint'($signed(d[COEF_W-1:0]));
      REG_COEF_CY: k_cy = longint'($signed(d[OFS_W-1:0]));
      default: ;
    endcase
  endfunction

  // Sends one item; valid stays high after the transaction so back-to-back
  // items never lower and raise it in one step.
  task automatic send_item(input item_kind_t k, input logic [POS_W-1:0] x, y,
                           input logic [PIX_W-1:0] p);
    int a;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= k;
    pos_x <= x;
    pos_y <= y;
    pixel_in <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (k == KIND_LOAD) begin
      n_loads++;
      if (x < MEM_W && y < MEM_H) begin
        a = int'(y) * MEM_W + int'(x);
        src_pix[a] = p;
        loaded[a] = 1'b1;
      end
    end else begin
      n_computes++;
      pending_pixels.push_back(rotate_pixel(x, y));
    end
  endtask

  task automatic load_if_missing(input int a);
    if (!loaded[a]) send_item(KIND_LOAD, POS_W'(a % MEM_W), POS_W'(a / MEM_W), 8'($urandom));
  endtask

  // Loads any unwritten neighbor first so no unwritten source entry is read.
  task automatic compute_pixel(input logic [POS_W-1:0] x, y);
    int base;
    base = neighborhood(x, y);
    if (base >= 0) begin
      load_if_missing(base);
      load_if_missing(base + 1);
      load_if_missing(base + MEM_W);
      load_if_missing(base + MEM_W + 1);
    end
    send_item(KIND_COMPUTE, x, y, 8'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input longint value);
    cfg_valid <= 1'b1;
    cfg_index <= CIDX_W'(idx);
    cfg_data <= CDATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_config(CIDX_W'(idx), CDATA_W'(value));
    n_cfg++;
  endtask

  task automatic set_mapping(input int w, h, input longint ax, bx, cx, ay, by, cy);
    wait_idle();
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_COEF_AX, ax);
    write_reg(REG_COEF_BX, bx);
    write_reg(REG_COEF_CX, cx);
    write_reg(REG_COEF_AY, ay);
    write_reg(REG_COEF_BY, by);
    write_reg(REG_COEF_CY, cy);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    rot_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_pixels.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        exp_r = pending_pixels.pop_front();
        if (exp_r.in_src) n_inside++;
        if (pixel_out !== exp_r.pix) begin
          $error("pixel_out expected %0d got %0d", exp_r.pix, pixel_out);
          errors++;
        end
        if (inside_res !== exp_r.in_src) begin
          $error("inside_res expected %0d got %0d", exp_r.in_src, inside_res);
          errors++;
        end
        if (map_x !== exp_r.mx) begin
          $error("map_x expected %0d got %0d", exp_r.mx, map_x);
          errors++;
        end
        if (map_y !== exp_r.my) begin
          $error("map_y expected %0d got %0d", exp_r.my, map_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("image_rotate_bilinear_fixed_unit_test: done, errors");
        $finish;
      end
    end
  end

  task automatic test_reset_mapping();
    for (int i = 0; i < 4; i++) compute_pixel(POS_W'(i), POS_W'(3 - i));
    compute_pixel(10'd510, 10'd510);
    compute_pixel(10'd511, 10'd0);
    compute_pixel(10'd1023, 10'd1023);
  endtask

  task automatic test_load_extremes();
    send_item(KIND_LOAD, 10'd0, 10'd0, 8'd255);
    send_item(KIND_LOAD, 10'd1, 10'd0, 8'd0);
    send_item(KIND_LOAD, 10'd1023, 10'd0, 8'd77);   // outside memory, dropped
    send_item(KIND_LOAD, 10'd0, 10'd700, 8'd99);    // outside memory, dropped
    send_item(KIND_LOAD, 10'd511, 10'd511, 8'd128);
    compute_pixel(10'd0, 10'd0);
  endtask

  task automatic test_register_extremes();
    // Fractional offsets and negative steps.
    set_mapping(4, 4, -256, 256, 3 * 256 + 128, 256, -256, 1 * 256 + 200);
    for (int i = 0; i < 4; i++) compute_pixel(POS_W'(i), POS_W'(i));
    // Largest offsets land far outside; maps wrap.
    set_mapping(1023, 513, 256, 256, 1048575, -256, -256, -1048576);
    compute_pixel(10'd0, 10'd0);
    compute_pixel(10'd1023, 10'd1023);
    // Widths below two make every pixel outside.
    set_mapping(1, 0, 256, 0, 0, 0, 256, 0);
    compute_pixel(10'd0, 10'd0);
    set_mapping(2, 2, 0, 0, 128, 0, 0, 255);
    compute_pixel(10'd5, 10'd9);
    // Indexes past the register list must be ignored.
    wait_idle();
    for (int i = NUM_REGS; i < 16; i++) write_reg(i, $urandom);
    cfg_valid <= 1'b0;
    compute_pixel(10'd1, 10'd1);
  endtask

  task automatic test_random_phase(input int idle_pct, stall_pct, n);
    int w, h, ang_c, ang_s, x0, y0, start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = n_loads + n_computes;
    while (n_loads + n_computes - start < n) begin
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(2, 48);
        h = $urandom_range(2, 48);
        if ($urandom_range(7) == 0) w = $urandom_range(0, 1023);
        ang_c = $urandom_range(0, 512) - 256;
        ang_s = $urandom_range(0, 512) - 256;
        set_mapping(w, h, ang_c, -ang_s, $urandom_range(0, 24 * 256), ang_s, ang_c,
                    $urandom_range(0, 24 * 256));
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          // Short raster run of destination pixels.
          x0 = $urandom_range(0, 40);
          y0 = $urandom_range(0, 40);
          for (int i = 0; i < 8; i++) compute_pixel(POS_W'(x0 + i), POS_W'(y0));
        end
        6, 7: begin
          send_item(KIND_LOAD, POS_W'($urandom), POS_W'($urandom), 8'($urandom));
        end
        default: begin
          compute_pixel(POS_W'($urandom), POS_W'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    src_w = 512;
    src_h = 512;
    k_ax = 256; k_bx = 0; k_cx = 0;
    k_ay = 0; k_by = 256; k_cy = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_mapping();
    test_load_extremes();
    test_register_extremes();
    test_random_phase(0, 0, 400);
    test_random_phase(45, 0, 400);
    test_random_phase(0, 45, 400);
    test_random_phase(23, 23, 400);
    wait_idle();
    $display("Covered %0d loads, %0d computes, %0d config writes.", n_loads, n_computes,
             n_cfg);
    $display("Checked %0d results, %0d of them inside the source.", n_results, n_inside);
    if (errors == 0) begin
      $display("image_rotate_bilinear_fixed_unit_test: done, clean");
    end else begin
      $display("image_rotate_bilinear_fixed_unit_test: done, errors");
    end
    $finish;
  end

endmodule
